FILE: hdl/ccfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccfr_pkg: shared types and constants of the COBS/CRC frame receiver
// Holds status codes, controller states, command/status structs and CRC step.
// ----------------------------------------------------------------------------
package ccfr_pkg;

    localparam int DEF_MAX_PAYLOAD     = 32;
    localparam int DEF_RX_BUFFER_BYTES = 64;
    localparam int HEAD_BYTES          = 3;
    localparam int MIN_DECODED         = 5;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  LONG_CODE_BYTE = 8'hFF;

    localparam logic [0:0] REG_SYNC_BYTE = 1'b0;
    localparam logic [0:0] REG_ERROR_CMD = 1'b1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_COBS   = 3'd1,
        ST_BAD_LENGTH = 3'd2,
        ST_BAD_START  = 3'd3,
        ST_BAD_CRC    = 3'd4,
        ST_OVERFLOW   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEADER,
        S_PAYLOAD
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic take_byte;   // decode the accepted non-delimiter byte
        logic clear_frame; // reset per-frame state
        logic set_drop;
        logic clr_drop;
        logic load_remote; // latch payload byte 0 into remote error
        logic idx_clear;   // reset payload read index
        logic idx_step;    // advance payload read index
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic    drop;
        logic    frame_empty;
        logic    buffer_full;
        t_status status;
        logic    is_remote;
        logic    idx_last;
        logic    plen_zero;
    } t_stat;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

FILE: hdl/ccfr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccfr_if: valid/ready channel interfaces
// Input byte, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface ccfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ccfr_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic       is_header;
    logic [7:0] frame_command;
    logic [5:0] payload_length;
    logic [4:0] payload_index;
    logic [7:0] payload_byte;
    logic [7:0] remote_error;
    logic       last;
    modport source (output valid, output status, output is_header, output frame_command,
                    output payload_length, output payload_index, output payload_byte,
                    output remote_error, output last, input ready);
    modport sink   (input valid, input status, input is_header, input frame_command,
                    input payload_length, input payload_index, input payload_byte,
                    input remote_error, input last, output ready);
endinterface

interface ccfr_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [7:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/ccfr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccfr_datapath: COBS decode, CRC, frame checks and payload store
// Executes controller commands and reports frame status.
// ----------------------------------------------------------------------------
module ccfr_datapath #(
    parameter int MAX_PAYLOAD     = ccfr_pkg::DEF_MAX_PAYLOAD,
    parameter int RX_BUFFER_BYTES = ccfr_pkg::DEF_RX_BUFFER_BYTES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ccfr_pkg::t_cmd i_cmd,
    input  logic [7:0]     i_rx_byte,
    input  logic [7:0]     i_sync_byte,
    input  logic [7:0]     i_error_cmd,
    output ccfr_pkg::t_stat o_stat,
    output logic [7:0]     o_command,
    output logic [5:0]     o_plen,
    output logic [4:0]     o_index,
    output logic [7:0]     o_pbyte,
    output logic [7:0]     o_remote_error
);
    import ccfr_pkg::*;

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [6:0]  r_byte_count;
    logic        r_drop;
    logic [7:0]  r_code_rem;
    logic        r_long_code;
    logic        r_zero_pend;
    logic [6:0]  r_dec_count;
    logic [15:0] r_crc;
    logic [15:0] r_delay;
    logic [7:0]  r_head_start;
    logic [7:0]  r_head_len;
    logic [7:0]  r_head_cmd;
    logic [7:0]  r_remote;
    logic [7:0]  r_mem [MAX_PAYLOAD];
    logic [7:0]  r_rd_data;
    logic [AW-1:0] r_idx;

    // One decoded byte per cycle at most: either the pending zero or a data byte.
    logic       push;
    logic [7:0] push_val;
    logic [7:0] n_code_rem;
    logic       n_long_code;
    logic       n_zero_pend;
    logic [6:0] pidx;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic       wr_en;

    always_comb begin
        push        = 1'b0;
        push_val    = i_rx_byte;
        n_code_rem  = r_code_rem;
        n_long_code = r_long_code;
        n_zero_pend = r_zero_pend;
        if (r_code_rem == 8'd0) begin
            push        = r_zero_pend;
            push_val    = 8'd0;
            n_code_rem  = i_rx_byte - 8'd1;
            n_long_code = (i_rx_byte == LONG_CODE_BYTE);
            n_zero_pend = (i_rx_byte == 8'd1);
        end else begin
            push       = 1'b1;
            n_code_rem = r_code_rem - 8'd1;
            if (r_code_rem == 8'd1) n_zero_pend = !r_long_code;
        end
    end

    assign pidx    = r_dec_count - 7'(HEAD_BYTES);
    assign wr_addr = pidx[AW-1:0];
    assign wr_en   = push && (r_dec_count >= 7'(HEAD_BYTES))
                     && (pidx < 7'(MAX_PAYLOAD));

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte && wr_en) r_mem[wr_addr] <= push_val;
        r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        rd_addr = r_idx;
        if (i_cmd.idx_clear) rd_addr = '0;
        else if (i_cmd.idx_step) rd_addr = r_idx + AW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_drop       <= 1'b0;
            r_code_rem   <= '0;
            r_long_code  <= 1'b0;
            r_zero_pend  <= 1'b0;
            r_dec_count  <= '0;
            r_crc        <= CRC_INIT;
            r_delay      <= '0;
            r_head_start <= '0;
            r_head_len   <= '0;
            r_head_cmd   <= '0;
            r_remote     <= '0;
            r_idx        <= '0;
        end else begin
            r_idx <= rd_addr;
            if (i_cmd.set_drop) r_drop <= 1'b1;
            if (i_cmd.clr_drop) r_drop <= 1'b0;
            if (i_cmd.load_remote) r_remote <= r_rd_data;
            if (i_cmd.clear_frame) begin
                r_byte_count <= '0;
                r_code_rem   <= '0;
                r_long_code  <= 1'b0;
                r_zero_pend  <= 1'b0;
                r_dec_count  <= '0;
                r_crc        <= CRC_INIT;
                r_delay      <= '0;
                r_head_start <= '0;
                r_head_len   <= '0;
                r_head_cmd   <= '0;
            end else if (i_cmd.take_byte) begin
                r_byte_count <= r_byte_count + 7'd1;
                r_code_rem   <= n_code_rem;
                r_long_code  <= n_long_code;
                r_zero_pend  <= n_zero_pend;
                if (push) begin
                    if (r_dec_count == 7'd0) r_head_start <= push_val;
                    if (r_dec_count == 7'd1) r_head_len   <= push_val;
                    if (r_dec_count == 7'd2) r_head_cmd   <= push_val;
                    if (r_dec_count >= 7'd2) r_crc <= crc_byte(r_crc, r_delay[15:8]);
                    r_delay <= {r_delay[7:0], push_val};
                    if (r_dec_count != 7'd127) r_dec_count <= r_dec_count + 7'd1;
                end
            end
        end
    end

    // Frame check in priority order.
    logic [15:0] rx_crc;
    logic [8:0]  len_plus4;
    logic [7:0]  plen8;
    t_status     st;

    assign rx_crc    = {r_delay[7:0], r_delay[15:8]};
    assign len_plus4 = {1'b0, r_head_len} + 9'd4;
    assign plen8     = r_head_len - 8'd1;

    always_comb begin
        if (r_code_rem != 8'd0)                                  st = ST_BAD_COBS;
        else if (r_dec_count < 7'(MIN_DECODED))                  st = ST_BAD_LENGTH;
        else if (r_head_start != i_sync_byte)                    st = ST_BAD_START;
        else if (r_head_len == 8'd0 || {2'b0, r_dec_count} != len_plus4)
                                                                 st = ST_BAD_LENGTH;
        else if (rx_crc != r_crc)                                st = ST_BAD_CRC;
        else if (plen8 > 8'(MAX_PAYLOAD))                        st = ST_BAD_LENGTH;
        else                                                     st = ST_OK;
    end

    assign o_stat.drop        = r_drop;
    assign o_stat.frame_empty = (r_byte_count == 7'd0);
    assign o_stat.buffer_full = (r_byte_count >= 7'(RX_BUFFER_BYTES));
    assign o_stat.status      = st;
    assign o_stat.is_remote   = (r_head_cmd == i_error_cmd) && (plen8 != 8'd0);
    assign o_stat.idx_last    = ({{(8-AW){1'b0}}, r_idx} + 8'd1 == plen8);
    assign o_stat.plen_zero   = (plen8 == 8'd0);

    assign o_command      = r_head_cmd;
    assign o_plen         = plen8[5:0];
    assign o_index        = 5'(r_idx);
    assign o_pbyte        = r_rd_data;
    assign o_remote_error = r_remote;

endmodule

FILE: hdl/ccfr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccfr_ctrl: frame receiver controller
// Sequences byte intake, the header result and the payload result run.
// ----------------------------------------------------------------------------
module ccfr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_zero,
    output logic            o_in_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic            o_hdr,
    output logic            o_ok,
    output logic            o_ovf,
    output logic            o_last,
    input  ccfr_pkg::t_stat i_stat,
    output ccfr_pkg::t_cmd  o_cmd
);
    import ccfr_pkg::*;

    t_state r_state, n_state;
    logic   r_ovf, n_ovf;
    logic   acc;

    assign acc = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovf   <= n_ovf;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ovf   = r_ovf;
        case (r_state)
            S_IDLE: begin
                if (acc && i_in_zero && !i_stat.frame_empty && !i_stat.drop) begin
                    n_state = S_HEADER;
                    n_ovf   = 1'b0;
                end else if (acc && i_in_zero && !i_stat.frame_empty) begin
                    n_state = S_HEADER;
                    n_ovf   = 1'b0;
                end else if (acc && !i_in_zero && !i_stat.drop && i_stat.buffer_full) begin
                    n_state = S_HEADER;
                    n_ovf   = 1'b1;
                end
            end
            S_HEADER: begin
                if (i_out_ready) begin
                    if (r_ovf || i_stat.status != ST_OK || i_stat.plen_zero)
                        n_state = S_IDLE;
                    else
                        n_state = S_PAYLOAD;
                end
            end
            S_PAYLOAD: begin
                if (i_out_ready && i_stat.idx_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_hdr       = 1'b0;
        o_ok        = 1'b0;
        o_ovf       = r_ovf;
        o_last      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.idx_clear = 1'b1;
                if (acc && i_in_zero) begin
                    o_cmd.clr_drop = 1'b1;
                    // an empty frame is cleared here; a non-empty one after its results are given
                    if (i_stat.frame_empty) o_cmd.clear_frame = 1'b1;
                end else if (acc && !i_stat.drop) begin
                    if (i_stat.buffer_full) begin
                        o_cmd.set_drop    = 1'b1;
                        o_cmd.clear_frame = 1'b1;
                    end else begin
                        o_cmd.take_byte = 1'b1;
                    end
                end
            end
            S_HEADER: begin
                o_out_valid = 1'b1;
                o_hdr       = 1'b1;
                o_ok        = !r_ovf && (i_stat.status == ST_OK);
                o_last      = !o_ok || i_stat.plen_zero;
                if (i_out_ready) begin
                    if (o_ok && i_stat.is_remote) o_cmd.load_remote = 1'b1;
                    if (o_last) o_cmd.clear_frame = 1'b1;
                end
            end
            S_PAYLOAD: begin
                o_out_valid = 1'b1;
                o_ok        = 1'b1;
                o_last      = i_stat.idx_last;
                if (i_out_ready) begin
                    o_cmd.idx_step = 1'b1;
                    if (i_stat.idx_last) o_cmd.clear_frame = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: hdl/cobs_crc_frame_receiver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cobs_crc_frame_receiver_unit: COBS frame receiver with CRC-16 check
// Decodes COBS frames on the fly, checks them, and emits result transactions.
// ----------------------------------------------------------------------------
// channel | dir | carries
// in      | in  | rx_byte, one raw received byte per transaction
// out     | out | status/header/command/length/index/byte/remote error/last
// cfg     | in  | index 0 frame sync byte, index 1 error_command_code
//
// A non-delimiter byte is decoded in the cycle it is accepted, unless the frame is dropped.
// A delimiter closing a frame (or an overflowing byte) stops intake while the
// header result and up to MAX_PAYLOAD payload results drain, one per cycle
// the sink is ready; the payload store has one read port, so results are
// serial. Reset is synchronous; the payload store needs no clearing.
// ----------------------------------------------------------------------------
module cobs_crc_frame_receiver_unit #(
    parameter int MAX_PAYLOAD     = ccfr_pkg::DEF_MAX_PAYLOAD,
    parameter int RX_BUFFER_BYTES = ccfr_pkg::DEF_RX_BUFFER_BYTES
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ccfr_in_if.sink    in_ch,
    ccfr_out_if.source out_ch,
    ccfr_cfg_if.sink   cfg_ch
);
    import ccfr_pkg::*;

    logic [7:0] r_sync_byte;
    logic [7:0] r_error_cmd;

    t_cmd  cmd;
    t_stat stat;
    logic [7:0] command, pbyte, remote;
    logic [5:0] plen;
    logic [4:0] pidx;
    logic hdr, ok, ovf, last;

    // Configuration registers: always ready.
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte <= '0;
            r_error_cmd <= '0;
        end else if (cfg_ch.valid) begin
            case (cfg_ch.index)
                REG_SYNC_BYTE: r_sync_byte <= cfg_ch.data;
                REG_ERROR_CMD: r_error_cmd <= cfg_ch.data;
                default: ;
            endcase
        end
    end

    ccfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_in_zero   (in_ch.rx_byte == 8'd0),
        .o_in_ready  (in_ch.ready),
        .i_out_ready (out_ch.ready),
        .o_out_valid (out_ch.valid),
        .o_hdr       (hdr),
        .o_ok        (ok),
        .o_ovf       (ovf),
        .o_last      (last),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ccfr_datapath #(
        .MAX_PAYLOAD     (MAX_PAYLOAD),
        .RX_BUFFER_BYTES (RX_BUFFER_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_rx_byte      (in_ch.rx_byte),
        .i_sync_byte    (r_sync_byte),
        .i_error_cmd    (r_error_cmd),
        .o_stat         (stat),
        .o_command      (command),
        .o_plen         (plen),
        .o_index        (pidx),
        .o_pbyte        (pbyte),
        .o_remote_error (remote)
    );

    // Remote error reflects the header's own update (load happens on accept).
    logic [7:0] remote_now;
    assign remote_now = (hdr && ok && stat.is_remote) ? pbyte : remote;

    assign out_ch.status         = ovf ? ST_OVERFLOW : (hdr ? stat.status : ST_OK);
    assign out_ch.is_header      = hdr;
    assign out_ch.frame_command  = ok ? command : 8'd0;
    assign out_ch.payload_length = ok ? plen : 6'd0;
    assign out_ch.payload_index  = hdr ? 5'd0 : pidx;
    assign out_ch.payload_byte   = hdr ? 8'd0 : pbyte;
    assign out_ch.remote_error   = remote_now;
    assign out_ch.last           = last;

endmodule
